/* rtl/epmt_pkg.sv */
// Shared types and codes of the endpoint match table.
package epmt_pkg;

    // Item kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Input item
    typedef struct packed {
        logic        kind;
        logic [15:0] port;
        logic [31:0] ip_address;
        logic [15:0] handle;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_handle;
        logic        now_empty;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic hit;
        logic miss;
    } t_dp_sts;

endpackage

/* rtl/endpoint_match_table_top.sv */
// Top level of the endpoint match table: controller and datapath.
//
// Usage: a small associative table of busy endpoints keyed by port and
// IPv4 address. Input items arrive on i_in_valid / o_in_stall / i_in_item;
// an add stores the key and handle in the lowest free slot, a remove frees
// the lowest slot matching the key and returns its handle. Each item gives
// exactly one result on o_out_valid / i_out_stall / o_out_item, carrying a
// status, the found handle and whether the table is now empty.
// Operation: the slots are scanned one per cycle, lowest first, through the
// entry memory's registered read port; the result register loads and
// o_out_valid rises once the scan finds the item's slot, or once the last
// slot has been compared for a full table on add or a miss on remove. One
// item is in the scan at a time, so the next item is not accepted until
// the current item's result has been loaded into the result register.
// Reset empties the table (valid bits and count clear); entry contents are
// left as they are. A result waiting under i_out_stall does not block the
// next item's scan; that scan holds at its last step until the result
// register frees up.
module endpoint_match_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  epmt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output epmt_pkg::t_out_item o_out_item
);

    epmt_pkg::t_dp_cmd w_cmd;
    epmt_pkg::t_dp_sts w_sts;

    epmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    epmt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

/* rtl/epmt_datapath.sv */
// Table storage, slot scan, compare and result register of the endpoint match table.
module epmt_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  epmt_pkg::t_dp_cmd   i_cmd,
    output epmt_pkg::t_dp_sts   o_sts,
    input  epmt_pkg::t_in_item  i_in_item,
    output epmt_pkg::t_out_item o_out_item
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Entry memory: key is {port, address}
    logic [47:0] r_mem_key [TABLE_DEPTH];
    logic [15:0] r_mem_hnd [TABLE_DEPTH];

    // Scan control and occupancy
    logic [IDX_W-1:0]       r_idx;
    logic                   r_all;
    logic                   r_pv;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;

    // Payload registers
    epmt_pkg::t_in_item  r_item;
    epmt_pkg::t_out_item r_out;
    logic [IDX_W-1:0]    r_p_idx;
    logic [47:0]         r_p_key;
    logic [15:0]         r_p_hnd;

    logic w_slot_v;
    logic w_key_eq;
    logic w_match;
    logic w_is_add;

    // Compare the slot held in the registered read port
    assign w_is_add = (r_item.kind == epmt_pkg::KIND_ADD);
    assign w_slot_v = r_valid[r_p_idx];
    assign w_key_eq = (r_p_key == {r_item.port, r_item.ip_address});
    assign w_match  = r_pv && (w_is_add ? !w_slot_v : (w_slot_v && w_key_eq));

    assign o_sts.hit  = w_match;
    assign o_sts.miss = r_all && !r_pv;

    // Occupancy after this item
    always_comb begin
        n_count = r_count;
        if (i_cmd.commit && w_match) begin
            if (w_is_add) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    // Control state: scan index, read pipeline flag, valid bits, count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_all   <= 1'b0;
            r_pv    <= 1'b0;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                r_all <= 1'b0;
                r_pv  <= 1'b0;
            end else if (i_cmd.scan) begin
                if (!r_all) begin
                    r_pv  <= 1'b1;
                    r_all <= (r_idx == LAST_IDX);
                    if (r_idx != LAST_IDX) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end else begin
                    r_pv <= 1'b0;
                end
            end
            if (i_cmd.commit && w_match) begin
                r_valid[r_p_idx] <= w_is_add;
            end
            r_count <= n_count;
        end
    end

    // Payload: item capture, memory read and write, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.scan && !r_all) begin
            r_p_idx <= r_idx;
            r_p_key <= r_mem_key[r_idx];
            r_p_hnd <= r_mem_hnd[r_idx];
        end
        if (i_cmd.commit && w_match && w_is_add) begin
            r_mem_key[r_p_idx] <= {r_item.port, r_item.ip_address};
            r_mem_hnd[r_p_idx] <= r_item.handle;
        end
        if (i_cmd.commit) begin
            if (w_match) begin
                r_out.status <= epmt_pkg::ST_OK;
            end else if (w_is_add) begin
                r_out.status <= epmt_pkg::ST_FULL;
            end else begin
                r_out.status <= epmt_pkg::ST_NOT_FOUND;
            end
            r_out.found_handle <= (w_match && !w_is_add) ? r_p_hnd : 16'd0;
            r_out.now_empty    <= (n_count == '0);
        end
    end

    assign o_out_item = r_out;

endmodule

/* rtl/epmt_ctrl.sv */
// Controller of the endpoint match table: item handshake and scan sequencing.
module epmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output epmt_pkg::t_dp_cmd o_cmd,
    input  epmt_pkg::t_dp_sts i_sts
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;
    logic   r_out_vld;
    logic   w_out_free;
    logic   w_done;
    logic   w_finish;

    // Result register can take a new item
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_done     = i_sts.hit || i_sts.miss;
    assign w_finish   = (r_state == S_SCAN) && w_done && w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

    // Datapath commands
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.scan   = (r_state == S_SCAN) && !w_done;
    assign o_cmd.commit = w_finish;

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_finish) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

endmodule

/* bench/endpoint_table_checker.sv */
`timescale 1ns / 1ps
// Checker for the endpoint match table: shadow table, expected results and comparison.
module endpoint_table_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  epmt_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  epmt_pkg::t_out_item i_out_item,
    output int                  o_mismatches,
    output int                  o_pending
);

    // Shadow copy of the slot table
    logic        shadow_valid   [TABLE_DEPTH];
    logic [15:0] shadow_port    [TABLE_DEPTH];
    logic [31:0] shadow_address [TABLE_DEPTH];
    logic [15:0] shadow_handle  [TABLE_DEPTH];

    epmt_pkg::t_out_item pending_results[$];
    int                  mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Apply one add or remove to the shadow table and return its result
    function automatic epmt_pkg::t_out_item apply_table_op(input epmt_pkg::t_in_item it);
        epmt_pkg::t_out_item res;
        int                  slot;
        logic                any_valid;
        res = '0;
        res.status = epmt_pkg::ST_OK;
        slot = -1;
        if (it.kind == epmt_pkg::KIND_ADD) begin
            // lowest free slot
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot < 0 && !shadow_valid[i]) slot = i;
            end
            if (slot < 0) begin
                res.status = epmt_pkg::ST_FULL;
            end else begin
                shadow_valid[slot]   = 1'b1;
                shadow_port[slot]    = it.port;
                shadow_address[slot] = it.ip_address;
                shadow_handle[slot]  = it.handle;
            end
        end else begin
            // lowest valid slot with both key parts equal; handle plays no part
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot < 0 && shadow_valid[i] && shadow_port[i] == it.port
                        && shadow_address[i] == it.ip_address) slot = i;
            end
            if (slot < 0) begin
                res.status = epmt_pkg::ST_NOT_FOUND;
            end else begin
                res.found_handle   = shadow_handle[slot];
                shadow_valid[slot] = 1'b0;
            end
        end
        any_valid = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) any_valid = any_valid | shadow_valid[i];
        res.now_empty = !any_valid;
        return res;
    endfunction

    // Track accepted items, compare accepted results against the oldest expectation
    always @(posedge i_clk) begin : track
        epmt_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0d %h %0d",
                             $time, "actual status/handle/empty",
                             i_out_item.status, i_out_item.found_handle,
                             i_out_item.now_empty);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_item.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_out_item.status);
                        mismatch_count++;
                    end
                    if (i_out_item.found_handle !== want.found_handle) begin
                        $display("%0t: found_handle expected %h actual %h",
                                 $time, want.found_handle, i_out_item.found_handle);
                        mismatch_count++;
                    end
                    if (i_out_item.now_empty !== want.now_empty) begin
                        $display("%0t: now_empty expected %0d actual %0d",
                                 $time, want.now_empty, i_out_item.now_empty);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) pending_results.push_back(apply_table_op(i_in_item));
        end
        o_pending <= pending_results.size();
    end

endmodule

/* bench/endpoint_match_table_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the endpoint match table: clock, reset, item stimulus and verdict.
module endpoint_match_table_top_tb;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_ITEMS  = 200;
    localparam int KEY_HISTORY  = 48;

    typedef struct packed {
        logic [15:0] port;
        logic [31:0] addr;
    } t_key;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    epmt_pkg::t_in_item  i_in_item   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    epmt_pkg::t_out_item o_out_item;
    int                  mismatches;
    int                  results_waiting;

    // Idling controls, changed per phase
    int   gap_pct   = 10;
    int   stall_pct = 10;
    logic quiet     = 1'b0;

    t_key recent_keys[$];

    endpoint_match_table_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    endpoint_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_mismatches (mismatches),
        .o_pending    (results_waiting)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #8_000_000;
        $display("endpoint_match_table_top_tb: FAIL");
        $finish;
    end

    // Receiver stalls in random bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic epmt_pkg::t_in_item build_item(input logic kind, input t_key key,
                                                      input logic [15:0] handle);
        epmt_pkg::t_in_item it;
        it.kind       = kind;
        it.port       = key.port;
        it.ip_address = key.addr;
        it.handle     = handle;
        return it;
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.port = 16'($urandom);
        k.addr = $urandom;
        return k;
    endfunction

    // Offer one item, with an optional idle burst first; returns once accepted
    task automatic send_item(input epmt_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stimulus and verdict
    initial begin
        t_key key;
        t_key dup_key;
        int   idx;
        int   add_pct;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: remove on empty table
        key.port = 16'h1234;
        key.addr = 32'h0A00_0001;
        send_item(build_item(epmt_pkg::KIND_REMOVE, key, 16'h5A5A));
        // add one entry with all-ones fields, then remove it to empty the table
        key.port = 16'hFFFF;
        key.addr = 32'hFFFF_FFFF;
        send_item(build_item(epmt_pkg::KIND_ADD, key, 16'hFFFF));
        send_item(build_item(epmt_pkg::KIND_REMOVE, key, 16'h0000));
        // fill every slot; slots 3 and 9 share a key
        dup_key.port = 16'h3333;
        dup_key.addr = 32'h3333_3333;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            key.port = 16'(i * 16'h1111);
            key.addr = 32'(i * 32'h1111_1111);
            if (i == 9) key = dup_key;
            send_item(build_item(epmt_pkg::KIND_ADD, key, 16'(~(i * 16'h1111))));
        end
        // add on full table
        send_item(build_item(epmt_pkg::KIND_ADD, random_key(), 16'($urandom)));
        // port matches, address off by one bit
        key.port = 16'h2222;
        key.addr = 32'h2222_2223;
        send_item(build_item(epmt_pkg::KIND_REMOVE, key, 16'h2222));
        // duplicate key: lowest slot first, then the other; handle input is ignored
        send_item(build_item(epmt_pkg::KIND_REMOVE, dup_key, 16'($urandom)));
        send_item(build_item(epmt_pkg::KIND_REMOVE, dup_key, 16'($urandom)));
        // refill lowest free slot
        send_item(build_item(epmt_pkg::KIND_ADD, dup_key, 16'hBEEF));
        recent_keys.push_back(dup_key);

        // Random phase: removes mostly target keys added earlier
        add_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                add_pct   = $urandom_range(20, 85);
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 25);
            end
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            if ($urandom_range(0, 99) < add_pct) begin
                if (recent_keys.size() > 0 && $urandom_range(0, 9) == 0) begin
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                end else begin
                    key = random_key();
                end
                recent_keys.push_back(key);
                if (recent_keys.size() > KEY_HISTORY) void'(recent_keys.pop_front());
                send_item(build_item(epmt_pkg::KIND_ADD, key, 16'($urandom)));
            end else begin
                if (recent_keys.size() > 0 && $urandom_range(0, 99) < 85) begin
                    idx = $urandom_range(0, recent_keys.size() - 1);
                    key = recent_keys[idx];
                    recent_keys.delete(idx);
                    // near miss on one key bit now and then
                    if ($urandom_range(0, 9) == 0) begin
                        if ($urandom_range(0, 1) == 0) key.port[$urandom_range(0, 15)] ^= 1'b1;
                        else key.addr[$urandom_range(0, 31)] ^= 1'b1;
                    end
                end else begin
                    key = random_key();
                end
                send_item(build_item(epmt_pkg::KIND_REMOVE, key, 16'($urandom)));
            end
        end
        i_in_valid <= 1'b0;

        // Drain and settle
        @(posedge i_clk);
        while (results_waiting != 0) @(posedge i_clk);
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0 && results_waiting == 0) begin
            $display("endpoint_match_table_top_tb: PASS");
        end else begin
            $display("endpoint_match_table_top_tb: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/epmt_pkg.sv
rtl/epmt_datapath.sv
rtl/epmt_ctrl.sv
rtl/endpoint_match_table_top.sv
bench/endpoint_table_checker.sv
bench/endpoint_match_table_top_tb.sv
